// ----- sv/gmps_pkg.sv -----
package gmps_pkg;

    localparam int CELL_W        = 16;
    localparam int ROW_W         = 4;
    localparam int GRID_SIZE_DEF = 16;

    typedef struct packed {
        logic load_we;
        logic reach_init;
        logic reach_step;
        logic walk_init;
        logic walk_step;
        logic emit;
    } cmd_t;

    typedef struct packed {
        logic load_last;
        logic reach_last;
        logic found_now;
        logic at_exit;
        logic out_free;
        logic emit_last;
    } sts_t;

endpackage

// ----- sv/gmps_dp.sv -----
module gmps_dp #(
    parameter int GRID_SIZE = gmps_pkg::GRID_SIZE_DEF
) (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic [gmps_pkg::CELL_W-1:0] row_cells,
    input  gmps_pkg::cmd_t              cmd,
    output gmps_pkg::sts_t              sts,
    input  logic                        res_stall,
    output logic                        res_valid,
    output logic [gmps_pkg::ROW_W-1:0]  row_number,
    output logic [gmps_pkg::CELL_W-1:0] path_bits,
    output logic                        path_found,
    output logic                        last_row
);
    import gmps_pkg::*;

    localparam int RW = (GRID_SIZE > 1) ? $clog2(GRID_SIZE) : 1;
    localparam logic [RW-1:0]     LAST_IDX = RW'(GRID_SIZE - 1);
    localparam logic [CELL_W-1:0] COL_MASK = CELL_W'((33'd1 << GRID_SIZE) - 33'd1);
    localparam logic [CELL_W-1:0] EXIT_BIT = CELL_W'(33'd1 << (GRID_SIZE - 1));

    logic [CELL_W-1:0] grid_mem  [GRID_SIZE];
    logic [CELL_W-1:0] reach_mem [GRID_SIZE];
    logic [CELL_W-1:0] sol_mem   [GRID_SIZE];

    logic [RW-1:0]     load_cnt_reg;
    logic [RW-1:0]     ridx_reg;
    logic [CELL_W-1:0] below_reg;
    logic              found_reg;
    logic [RW-1:0]     row_reg;
    logic [RW-1:0]     col_reg;
    logic [CELL_W-1:0] acc_reg;
    logic [RW-1:0]     erow_reg;
    logic              res_valid_reg;
    logic [ROW_W-1:0]  row_number_reg;
    logic [CELL_W-1:0] path_bits_reg;
    logic              path_found_reg;
    logic              last_row_reg;

    logic [CELL_W-1:0] open_row;
    logic [CELL_W-1:0] exit_sel;
    logic [CELL_W-1:0] reach_row;
    logic [CELL_W-1:0] prop;
    logic [RW-1:0]     nxt_row;
    logic [RW-1:0]     nxt_col;
    logic [CELL_W-1:0] reach_below;
    logic              down_ok;
    logic              at_exit;

    // Reach of a row: a cell reaches the exit if open and either the cell below
    // reaches it or the run of open cells to its right hits such a cell.
    // Resolved as a log-depth prefix from high columns toward column 0.
    always_comb
    begin
        open_row  = grid_mem[ridx_reg] & COL_MASK;
        exit_sel  = (ridx_reg == LAST_IDX) ? EXIT_BIT : '0;
        reach_row = open_row & (below_reg | exit_sel);
        prop      = open_row;
        for (int k = 0; k < 4; k++)
        begin
            reach_row = reach_row | (prop & (reach_row >> (1 << k)));
            prop      = prop & (prop >> (1 << k));
        end
    end

    assign nxt_row     = row_reg + 1'b1;
    assign nxt_col     = col_reg + 1'b1;
    assign reach_below = reach_mem[nxt_row];
    assign at_exit     = (row_reg == LAST_IDX) && (col_reg == LAST_IDX);
    assign down_ok     = (row_reg != LAST_IDX) && reach_below[col_reg];

    assign sts.load_last  = (load_cnt_reg == LAST_IDX);
    assign sts.reach_last = (ridx_reg == '0);
    assign sts.found_now  = reach_row[0];
    assign sts.at_exit    = at_exit;
    assign sts.out_free   = !res_valid_reg || !res_stall;
    assign sts.emit_last  = (erow_reg == LAST_IDX);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            load_cnt_reg  <= '0;
            erow_reg      <= '0;
            res_valid_reg <= 1'b0;
        end
        else
        begin
            if (cmd.load_we)
            begin
                load_cnt_reg <= (load_cnt_reg == LAST_IDX) ? '0 : load_cnt_reg + 1'b1;
            end
            if (cmd.emit)
            begin
                erow_reg      <= (erow_reg == LAST_IDX) ? '0 : erow_reg + 1'b1;
                res_valid_reg <= 1'b1;
            end
            else if (!res_stall)
            begin
                res_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load_we)
        begin
            grid_mem[load_cnt_reg] <= row_cells;
        end

        if (cmd.reach_init)
        begin
            ridx_reg  <= LAST_IDX;
            below_reg <= '0;
        end
        else if (cmd.reach_step)
        begin
            reach_mem[ridx_reg] <= reach_row;
            below_reg           <= reach_row;
            ridx_reg            <= ridx_reg - 1'b1;
            if (ridx_reg == '0)
            begin
                found_reg <= reach_row[0];
            end
        end

        if (cmd.walk_init)
        begin
            row_reg <= '0;
            col_reg <= '0;
            acc_reg <= CELL_W'(1);
        end
        else if (cmd.walk_step)
        begin
            if (at_exit)
            begin
                sol_mem[row_reg] <= acc_reg;
            end
            else if (down_ok)
            begin
                // close this row and open the next one at the same column
                sol_mem[row_reg] <= acc_reg;
                row_reg          <= nxt_row;
                acc_reg          <= CELL_W'(1) << col_reg;
            end
            else
            begin
                col_reg <= nxt_col;
                acc_reg <= acc_reg | (CELL_W'(1) << nxt_col);
            end
        end

        if (cmd.emit)
        begin
            row_number_reg <= ROW_W'(erow_reg);
            path_bits_reg  <= found_reg ? sol_mem[erow_reg] : '0;
            path_found_reg <= found_reg;
            last_row_reg   <= (erow_reg == LAST_IDX);
        end
    end

    assign res_valid  = res_valid_reg;
    assign row_number = row_number_reg;
    assign path_bits  = path_bits_reg;
    assign path_found = path_found_reg;
    assign last_row   = last_row_reg;

endmodule

// ----- sv/gmps_ctrl.sv -----
module gmps_ctrl (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           row_valid,
    output logic           row_stall,
    input  gmps_pkg::sts_t sts,
    output gmps_pkg::cmd_t cmd
);
    import gmps_pkg::*;

    typedef enum logic [1:0] {
        S_LOAD,
        S_REACH,
        S_WALK,
        S_EMIT
    } state_t;

    state_t state_reg;
    state_t state_next;
    logic   row_stall_reg;
    logic   row_stall_next;

    always_comb
    begin
        cmd            = '0;
        state_next     = state_reg;
        row_stall_next = row_stall_reg;
        case (state_reg)
            S_LOAD:
            begin
                if (row_valid)
                begin
                    cmd.load_we = 1'b1;
                    if (sts.load_last)
                    begin
                        cmd.reach_init = 1'b1;
                        state_next     = S_REACH;
                        row_stall_next = 1'b1;
                    end
                end
            end
            S_REACH:
            begin
                cmd.reach_step = 1'b1;
                if (sts.reach_last)
                begin
                    if (sts.found_now)
                    begin
                        cmd.walk_init = 1'b1;
                        state_next    = S_WALK;
                    end
                    else
                    begin
                        state_next = S_EMIT;
                    end
                end
            end
            S_WALK:
            begin
                cmd.walk_step = 1'b1;
                if (sts.at_exit)
                begin
                    state_next = S_EMIT;
                end
            end
            S_EMIT:
            begin
                if (sts.out_free)
                begin
                    cmd.emit = 1'b1;
                    if (sts.emit_last)
                    begin
                        state_next     = S_LOAD;
                        row_stall_next = 1'b0;
                    end
                end
            end
            default:
            begin
                state_next     = S_LOAD;
                row_stall_next = 1'b0;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_LOAD;
            row_stall_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            row_stall_reg <= row_stall_next;
        end
    end

    assign row_stall = row_stall_reg;

endmodule

// ----- sv/grid_maze_path_search.sv -----
// Maze path search over a GRID_SIZE x GRID_SIZE grid, moves down or right,
// down preferred. Rows enter one per beat, top row first. The beat that
// completes the grid stalls the row channel while the search runs: the reach
// table is swept bottom-up one row per cycle, then, if the top-left cell
// reaches the exit, the walk makes one move per cycle. Then GRID_SIZE result
// beats go out, one per cycle while res_stall is low, and the row channel
// opens again once the last result is in the output register.
module grid_maze_path_search #(
    parameter int GRID_SIZE = gmps_pkg::GRID_SIZE_DEF
) (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        row_valid,
    output logic                        row_stall,
    input  logic [gmps_pkg::CELL_W-1:0] row_cells,
    output logic                        res_valid,
    input  logic                        res_stall,
    output logic [gmps_pkg::ROW_W-1:0]  row_number,
    output logic [gmps_pkg::CELL_W-1:0] path_bits,
    output logic                        path_found,
    output logic                        last_row
);
    import gmps_pkg::*;

    cmd_t cmd;
    sts_t sts;

    gmps_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .row_valid (row_valid),
        .row_stall (row_stall),
        .sts       (sts),
        .cmd       (cmd)
    );

    gmps_dp #(
        .GRID_SIZE (GRID_SIZE)
    ) u_dp (
        .clk        (clk),
        .rst_n      (rst_n),
        .row_cells  (row_cells),
        .cmd        (cmd),
        .sts        (sts),
        .res_stall  (res_stall),
        .res_valid  (res_valid),
        .row_number (row_number),
        .path_bits  (path_bits),
        .path_found (path_found),
        .last_row   (last_row)
    );

endmodule
